// ----- rtl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted-list priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int DataW = 8;
  localparam int PrioW = 8;

  // request type codes
  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } spq_status_t;

  // operation broadcast to every cell
  typedef struct packed {
    logic             enq;
    logic             deq;
    logic [DataW-1:0] data;
    logic [PrioW-1:0] prio;
  } spq_cmd_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic             keep;
    logic [DataW-1:0] data;
    logic [PrioW-1:0] prio;
  } spq_link_t;

  // virtual neighbor left of the head cell: always keeps
  localparam spq_link_t HEAD_LINK = '{keep: 1'b1, data: '0, prio: '0};

endpackage

`default_nettype wire

// ----- rtl/stable_priority_queue_core.sv -----
// ----------------------------------------------------------------------------
// stable_priority_queue_core
// Bounded priority queue kept sorted in a chain of cells; lower priority
// value leaves first, equal priorities leave in arrival order.
// ----------------------------------------------------------------------------
// result: strobed on done in the cycle after the request is accepted
// throughput: one request per cycle, busy stays low; every cell updates in
//   parallel from its own compare and its neighbors
// reset: entry count cleared to zero, done low; entry contents left as is
// results cannot be stalled by the receiver
`default_nettype none

module stable_priority_queue_core #(
  parameter int DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         req_type,
  input  logic [7:0]                   item_data,
  input  logic [7:0]                   item_priority,
  output logic                         done,
  output logic [1:0]                   status,
  output logic [7:0]                   out_data,
  output logic [7:0]                   out_priority,
  output logic [$clog2(DEPTH+1)-1:0]   fill_level
);
  import spq_pkg::*;

  localparam int CountW = $clog2(DEPTH + 1);

  logic              accept;
  logic              full;
  logic              empty;
  logic [CountW-1:0] count;
  logic [CountW-1:0] count_next;
  spq_cmd_t          cmd;
  spq_link_t         links [DEPTH];

  assign busy   = 1'b0;
  assign accept = start & ~busy;
  assign full   = (count == CountW'(DEPTH));
  assign empty  = (count == '0);

  // gated operation for the chain
  always_comb begin
    cmd.enq  = accept & (req_type == REQ_ENQ) & ~full;
    cmd.deq  = accept & (req_type == REQ_DEQ) & ~empty;
    cmd.data = item_data;
    cmd.prio = item_priority;
  end

  // chain of cells, head at index zero
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_link_t left_link;
    spq_link_t right_link;
    if (i == 0) begin : g_head
      assign left_link = HEAD_LINK;
    end else begin : g_mid
      assign left_link = links[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_link = links[i];
    end else begin : g_body
      assign right_link = links[i+1];
    end
    spq_cell u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .occ   (count > CountW'(i)),
      .left  (left_link),
      .right (right_link),
      .link  (links[i])
    );
  end

  // entry count
  always_comb begin
    count_next = count;
    if (cmd.enq) begin
      count_next = count + CountW'(1);
    end else if (cmd.deq) begin
      count_next = count - CountW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data     <= '0;
      out_priority <= '0;
      status       <= ST_OK;
      if (req_type == REQ_ENQ) begin
        if (full) begin
          status <= ST_FULL;
        end
      end else if (empty) begin
        status <= ST_EMPTY;
      end else begin
        out_data     <= links[0].data;
        out_priority <= links[0].prio;
      end
    end
  end

  assign fill_level = count;

`ifndef ASSERT_OFF
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done) else $error("no result beat after accepted request");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !accept |=> !done) else $error("result beat without request");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CountW'(DEPTH)) else $error("entry count beyond depth");

  a_empty_level: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_EMPTY |-> fill_level == '0)
    else $error("empty status with entries held");

  a_full_level: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_FULL |-> fill_level == CountW'(DEPTH))
    else $error("full status with free slots");
`endif

endmodule

`default_nettype wire

// ----- rtl/spq_cell.sv -----
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, keeps it, takes the new
// entry or shifts from a neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
  input  logic              clk,
  input  spq_pkg::spq_cmd_t cmd,
  input  logic              occ,
  input  spq_pkg::spq_link_t left,
  input  spq_pkg::spq_link_t right,
  output spq_pkg::spq_link_t link
);
  import spq_pkg::*;

  logic [DataW-1:0] data;
  logic [PrioW-1:0] prio;
  logic             keep;

  // an occupied entry stays put when the newcomer ranks behind it
  assign keep = occ & (prio <= cmd.prio);
  assign link = '{keep: keep, data: data, prio: prio};

  // insert opens a gap behind the last kept entry, remove shifts toward head
  always_ff @(posedge clk) begin
    if (cmd.enq) begin
      if (!keep) begin
        if (left.keep) begin
          data <= cmd.data;
          prio <= cmd.prio;
        end else begin
          data <= left.data;
          prio <= left.prio;
        end
      end
    end else if (cmd.deq) begin
      data <= right.data;
      prio <= right.prio;
    end
  end

endmodule

`default_nettype wire
